// ===== hw/rtl/sparse_cost_table_unit_macros.svh =====
// Assertion helpers used by the checker file of this block.
`ifndef SPARSE_COST_TABLE_UNIT_MACROS_SVH
`define SPARSE_COST_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sct_pkg.sv =====
package sct_pkg;

   localparam int FUNC_W      = 2;
   localparam int ROW_W       = 10;
   localparam int COL_W       = 10;
   localparam int SIM_W       = 16;
   localparam int COST_W      = 17;
   localparam int STATUS_W    = 2;
   localparam int ROW_COUNT_W = 4;
   localparam int REG_W       = 11;
   localparam int CSR_IDX_W   = 8;

   // Column limit of the table; only behaviour depends on it.
   localparam int MAX_COLS    = 1024;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_ROWS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COLS = 8'd1;

   localparam logic [REG_W-1:0]  REG_RESET = 11'd1024;
   localparam logic [COST_W-1:0] COST_INF  = 17'h1FFFF;
   localparam logic [COST_W-1:0] ONE_Q15   = 17'd32768;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_INSERT,
      OP_LOOKUP,
      OP_BAD
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic               row_ok;
      logic               col_ok;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [COST_W-1:0]  cost;
   } item_type;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [COST_W-1:0] cost;
   } entry_type;

   typedef enum logic [2:0] {
      BK_INIT,
      BK_IDLE,
      BK_COUNT,
      BK_SCAN,
      BK_PLACE,
      BK_DONE
   } back_state_type;

endpackage

// ===== hw/rtl/sct_if.sv =====
interface sct_req_if import sct_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic [ROW_W-1:0]         row;
   logic [COL_W-1:0]         col;
   logic signed [SIM_W-1:0]  similarity;

   modport source (output valid, func, row, col, similarity, input ready);
   modport sink (input valid, func, row, col, similarity, output ready);
endinterface

interface sct_rsp_if import sct_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [COST_W-1:0]       cost;
   logic                    found;
   logic [STATUS_W-1:0]     status;
   logic [ROW_COUNT_W-1:0]  row_count;

   modport source (output valid, cost, found, status, row_count, input ready);
   modport sink (input valid, cost, found, status, row_count, output ready);
endinterface

interface sct_csr_if import sct_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  idx;
   logic [REG_W-1:0]      data;

   modport source (output valid, idx, data, input ready);
   modport sink (input valid, idx, data, output ready);
endinterface

// ===== hw/rtl/sparse_cost_table_unit.sv =====
// An item passes from the input through the queue, the back end's count state,
// a row walk where needed (none for a clear, an empty row or a refused item)
// and its done state into the output register. The back end takes one item at
// a time and walks a row through the single read port of the entry memory,
// one slot per cycle. Reset: synchronous, active high; afterwards the per-row
// counts are cleared one row per cycle while no input transfer is taken.
module sparse_cost_table_unit import sct_pkg::*; #(
   parameter int MAX_ROWS = 1024,
   parameter int SLOTS    = 8
) (
   input  logic       clock,
   input  logic       reset,
   sct_req_if.sink    req_chan,
   sct_rsp_if.source  rsp_chan,
   sct_csr_if.sink    csr_chan
);

   // The front end holds the two limit registers and classifies each item as
   // it is transferred in: the operation, whether its row and column fall
   // within the limits, and the cost that an insert would store.
   logic      push;
   item_type  push_item;
   logic      q_full;
   logic      init_done;

   // Between the two sides sits a short queue, so that items keep arriving
   // while the back end walks a row or waits for its result to be taken.
   logic      pop;
   logic      head_valid;
   item_type  head_item;

   sct_front #(.MAX_ROWS(MAX_ROWS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .init_done (init_done),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   sct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // The back end owns the count memory and the entry memory. It reads the
   // row's count, then walks the row one slot per cycle: upwards from slot 0
   // for a lookup until the first match, or downwards from the top entry for
   // an insert, moving each larger column up a slot until the new entry's
   // place is found. The result waits in an output register until it is
   // transferred, so a stalled consumer holds up the back end, and the input once the queue is full.
   sct_back #(.MAX_ROWS(MAX_ROWS), .SLOTS(SLOTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .init_done  (init_done),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== hw/rtl/sct_ram.sv =====
module sct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sct_front.sv =====
module sct_front import sct_pkg::*; #(
   parameter int MAX_ROWS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   sct_req_if.sink    req_chan,
   sct_csr_if.sink    csr_chan,
   input  logic       init_done,
   input  logic       q_full,
   output logic       push,
   output item_type   push_item
);

   logic [REG_W-1:0] num_rows_ff, num_rows_in;
   logic [REG_W-1:0] num_cols_ff, num_cols_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_chan.valid) begin
         case (csr_chan.idx)
            REG_NUM_ROWS: num_rows_in = csr_chan.data;
            REG_NUM_COLS: num_cols_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= REG_RESET;
         num_cols_ff <= REG_RESET;
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
      end
   end

   // No item enters while the count store is being swept after reset.
   assign req_chan.ready = init_done && !q_full;
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      push_item.row    = req_chan.row;
      push_item.col    = req_chan.col;
      push_item.row_ok = ({1'b0, req_chan.row} < num_rows_ff) &&
                         (32'(req_chan.row) < 32'(MAX_ROWS));
      push_item.col_ok = ({1'b0, req_chan.col} < num_cols_ff) &&
                         (32'(req_chan.col) < 32'(MAX_COLS));
      // Cost is one minus the similarity in Q1.15, always within 1 to 65536.
      push_item.cost   = ONE_Q15 - COST_W'(req_chan.similarity);
      case (req_chan.func)
         FUNC_CLEAR:  push_item.kind = OP_CLEAR;
         FUNC_INSERT: push_item.kind = OP_INSERT;
         FUNC_LOOKUP: push_item.kind = OP_LOOKUP;
         default:     push_item.kind = OP_BAD;
      endcase
   end

endmodule

// ===== hw/rtl/sct_queue.sv =====
module sct_queue import sct_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  item_type  push_item,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output item_type  head_item
);

   localparam int QP_W = $clog2(QUEUE_DEPTH);
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  fill_ff, fill_in;

   assign full       = (fill_ff == QC_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/sct_back.sv =====
module sct_back import sct_pkg::*; #(
   parameter int MAX_ROWS = 1024,
   parameter int SLOTS    = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  item_type   head_item,
   output logic       pop,
   output logic       init_done,
   sct_rsp_if.source  rsp_chan
);

   localparam int RAW   = $clog2(MAX_ROWS);
   localparam int EAW   = $clog2(MAX_ROWS * SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int ENT_W = $bits(entry_type);

   back_state_type           state_ff, state_in;
   logic [RAW-1:0]           init_ptr_ff, init_ptr_in;
   item_type                 cur_ff, cur_in;
   logic [EAW-1:0]           base_ff, base_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [CNT_W-1:0]         chk_ff, chk_in;

   logic [COST_W-1:0]        res_cost_ff, res_cost_in;
   logic                     res_found_ff, res_found_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [ROW_COUNT_W-1:0]   res_count_ff, res_count_in;

   logic                     out_valid_ff, out_valid_in;
   logic [COST_W-1:0]        out_cost_ff, out_cost_in;
   logic                     out_found_ff, out_found_in;
   logic [STATUS_W-1:0]      out_status_ff, out_status_in;
   logic [ROW_COUNT_W-1:0]   out_count_ff, out_count_in;

   logic                     cnt_we;
   logic [RAW-1:0]           cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]         cnt_wdata, cnt_rdata;
   logic                     ent_we;
   logic [EAW-1:0]           ent_waddr, ent_raddr;
   entry_type                ent_wdata, ent_rd, new_entry;
   logic [ENT_W-1:0]         ent_rdata;

   logic                     scan_go, hit, last, shift, out_free;

   sct_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   sct_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ROWS * SLOTS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   assign ent_rd    = entry_type'(ent_rdata);
   assign new_entry = '{col: cur_ff.col, cost: cur_ff.cost};
   assign init_done = (state_ff != BK_INIT);
   assign out_free  = !out_valid_ff || rsp_chan.ready;

   // A row walk is needed for a lookup in a non-empty row, or for an insert
   // into a row that already holds entries but still has room.
   assign scan_go = cur_ff.row_ok && cur_ff.col_ok && (cnt_rdata != '0) &&
                    ((cur_ff.kind == OP_LOOKUP) ||
                     ((cur_ff.kind == OP_INSERT) && (cnt_rdata < CNT_W'(SLOTS))));
   assign hit     = (ent_rd.col == cur_ff.col);
   assign last    = (chk_ff == n_ff - 1'b1);
   assign shift   = (ent_rd.col > cur_ff.col);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_INIT: begin
            if (init_ptr_ff == RAW'(MAX_ROWS - 1)) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (head_valid) state_in = BK_COUNT;
         end
         BK_COUNT: begin
            state_in = scan_go ? BK_SCAN : BK_DONE;
         end
         BK_SCAN: begin
            if (cur_ff.kind == OP_LOOKUP) begin
               if (hit || last) state_in = BK_DONE;
            end else if (shift) begin
               if (chk_ff == '0) state_in = BK_PLACE;
            end else begin
               state_in = BK_DONE;
            end
         end
         BK_PLACE: begin
            state_in = BK_DONE;
         end
         BK_DONE: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_INIT;
      endcase
   end

   always_comb begin
      init_ptr_in   = init_ptr_ff;
      cur_in        = cur_ff;
      base_in       = base_ff;
      n_in          = n_ff;
      chk_in        = chk_ff;
      res_cost_in   = res_cost_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      pop           = 1'b0;
      cnt_we        = 1'b0;
      cnt_waddr     = RAW'(cur_ff.row);
      cnt_wdata     = n_ff + 1'b1;
      cnt_raddr     = RAW'(head_item.row);
      ent_we        = 1'b0;
      ent_waddr     = base_ff + EAW'(chk_ff) + EAW'(1);
      ent_wdata     = new_entry;
      ent_raddr     = base_ff;

      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_cost_in   = out_cost_ff;
      out_found_in  = out_found_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;

      case (state_ff)
         BK_INIT: begin
            cnt_we      = 1'b1;
            cnt_waddr   = init_ptr_ff;
            cnt_wdata   = '0;
            init_ptr_in = init_ptr_ff + 1'b1;
         end
         BK_IDLE: begin
            if (head_valid) begin
               pop     = 1'b1;
               cur_in  = head_item;
               base_in = EAW'(32'(head_item.row) * 32'(SLOTS));
            end
         end
         BK_COUNT: begin
            n_in          = cnt_rdata;
            res_found_in  = 1'b0;
            res_status_in = ST_OK;
            res_cost_in   = (cur_ff.kind == OP_LOOKUP) ? COST_INF : '0;
            res_count_in  = cur_ff.row_ok ? ROW_COUNT_W'(cnt_rdata) : '0;
            if (!cur_ff.row_ok) begin
               res_status_in = ST_RANGE;
            end else begin
               case (cur_ff.kind)
                  OP_CLEAR: begin
                     cnt_we       = 1'b1;
                     cnt_wdata    = '0;
                     res_count_in = '0;
                  end
                  OP_INSERT: begin
                     if (!cur_ff.col_ok) begin
                        res_status_in = ST_RANGE;
                     end else if (cnt_rdata >= CNT_W'(SLOTS)) begin
                        res_status_in = ST_FULL;
                     end else if (cnt_rdata == '0) begin
                        ent_we       = 1'b1;
                        ent_waddr    = base_ff;
                        cnt_we       = 1'b1;
                        cnt_wdata    = CNT_W'(1);
                        res_count_in = ROW_COUNT_W'(1);
                     end else begin
                        // Walk down from the top entry of the row.
                        chk_in    = cnt_rdata - 1'b1;
                        ent_raddr = base_ff + EAW'(cnt_rdata - 1'b1);
                     end
                  end
                  OP_LOOKUP: begin
                     if (!cur_ff.col_ok) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        chk_in    = '0;
                        ent_raddr = base_ff;
                     end
                  end
                  default: res_status_in = ST_RANGE;
               endcase
            end
         end
         BK_SCAN: begin
            if (cur_ff.kind == OP_LOOKUP) begin
               // The next slot is read ahead while this one is compared.
               chk_in    = last ? chk_ff : chk_ff + 1'b1;
               ent_raddr = base_ff + EAW'(chk_in);
               if (hit) begin
                  res_cost_in  = ent_rd.cost;
                  res_found_in = 1'b1;
               end
            end else if (shift) begin
               // Move this entry up by one slot and read the one below.
               ent_we    = 1'b1;
               ent_wdata = ent_rd;
               if (chk_ff != '0) begin
                  chk_in    = chk_ff - 1'b1;
                  ent_raddr = base_ff + EAW'(chk_ff - 1'b1);
               end
            end else begin
               ent_we       = 1'b1;
               cnt_we       = 1'b1;
               res_count_in = ROW_COUNT_W'(n_ff + 1'b1);
            end
         end
         BK_PLACE: begin
            ent_we       = 1'b1;
            ent_waddr    = base_ff;
            cnt_we       = 1'b1;
            res_count_in = ROW_COUNT_W'(n_ff + 1'b1);
         end
         BK_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_cost_in   = res_cost_ff;
               out_found_in  = res_found_ff;
               out_status_in = res_status_ff;
               out_count_in  = res_count_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_INIT;
         init_ptr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ptr_ff  <= init_ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      base_ff       <= base_in;
      n_ff          <= n_in;
      chk_ff        <= chk_in;
      res_cost_ff   <= res_cost_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      out_cost_ff   <= out_cost_in;
      out_found_ff  <= out_found_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.cost      = out_cost_ff;
   assign rsp_chan.found     = out_found_ff;
   assign rsp_chan.status    = out_status_ff;
   assign rsp_chan.row_count = out_count_ff;

endmodule

// ===== hw/rtl/sct_checker.sv =====
`include "sparse_cost_table_unit_macros.svh"

module sct_checker import sct_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [COST_W-1:0]       rsp_cost,
   input logic                    rsp_found,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic [ROW_COUNT_W-1:0]  rsp_row_count
);

   logic req_seen;
   assign req_seen = req_valid && req_ready;

   `SCT_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   `SCT_ASSERT_IMP(a_found_ok, clock, reset, rsp_valid && rsp_found, (rsp_status == ST_OK) && (rsp_cost != COST_INF) && (rsp_cost != '0) && (rsp_row_count != '0), "match with bad status, cost or count")

   `SCT_ASSERT_IMP(a_full_quiet, clock, reset, rsp_valid && (rsp_status == ST_FULL), !rsp_found && (rsp_cost == '0), "refused insert reports a cost")

   `SCT_ASSERT_IMP(a_sweep_blocks, clock, reset, $fell(reset), !req_ready && !req_seen && !rsp_valid, "input taken during count sweep")

endmodule

bind sparse_cost_table_unit sct_checker u_sct_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_cost      (rsp_chan.cost),
   .rsp_found     (rsp_chan.found),
   .rsp_status    (rsp_chan.status),
   .rsp_row_count (rsp_chan.row_count)
);
